@@ hw/rtl/rhs_pkg.sv @@
package rhs_pkg;

  localparam int HASH_W      = 64;
  localparam int MAX_PROXIES = 6;
  localparam int IDX_W       = 3;
  localparam int PORT_W      = 14;
  localparam int WEIGHT_W    = 3;
  localparam int DIGITS      = 4;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam logic [PORT_W-1:0] BASE_PORT = 14'd9993;

  // ASCII digits of each proxy port, most significant first (9993 .. 9998)
  localparam logic [7:0] PORT_ASCII [MAX_PROXIES][DIGITS] = '{
    '{8'h39, 8'h39, 8'h39, 8'h33},
    '{8'h39, 8'h39, 8'h39, 8'h34},
    '{8'h39, 8'h39, 8'h39, 8'h35},
    '{8'h39, 8'h39, 8'h39, 8'h36},
    '{8'h39, 8'h39, 8'h39, 8'h37},
    '{8'h39, 8'h39, 8'h39, 8'h38}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_MOD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                done;
    logic [WEIGHT_W-1:0] rem;
  } mod_status_t;

endpackage

@@ hw/rtl/rhs_fold_unit.sv @@
module rhs_fold_unit
  import rhs_pkg::*;
(
  input  logic [HASH_W-1:0] hash_in,
  input  logic [7:0]        byte_in,
  output logic [HASH_W-1:0] hash_out
);

  // djb2 step: h*33 + b, wrapping
  assign hash_out = (hash_in << 5) + hash_in + {{(HASH_W-8){1'b0}}, byte_in};

endmodule

@@ hw/rtl/rhs_mod6_unit.sv @@
module rhs_mod6_unit
  import rhs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] value,
  output mod_status_t       status
);

  localparam int CHUNK_W = 16;
  localparam int CHUNKS  = HASH_W / CHUNK_W;
  localparam int CNT_W   = $clog2(CHUNKS);

  logic [HASH_W-1:0]   val_r, val_nxt;
  logic [1:0]          r3_r, r3_nxt;
  logic                par_r, par_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [1:0]          step_r3;

  // 4 == 1 mod 3, so x mod 3 is the sum of its 2-bit pieces mod 3;
  // folds one 16-bit chunk into the running residue r
  function automatic logic [1:0] chunk_mod3(input logic [CHUNK_W-1:0] c,
                                            input logic [1:0] r);
    logic [4:0] t;
    t = {3'b000, r};
    for (int k = 0; k < CHUNK_W / 2; k++) t = t + {3'b000, c[2*k +: 2]};
    if (t >= 5'd24) t = t - 5'd24;
    if (t >= 5'd12) t = t - 5'd12;
    if (t >= 5'd6)  t = t - 5'd6;
    if (t >= 5'd3)  t = t - 5'd3;
    return t[1:0];
  endfunction

  assign step_r3 = chunk_mod3(val_r[HASH_W-1 -: CHUNK_W], r3_r);

  always_comb begin
    val_nxt  = val_r;
    r3_nxt   = r3_r;
    par_nxt  = par_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      val_nxt  = value;
      r3_nxt   = '0;
      par_nxt  = value[0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = val_r << CHUNK_W;
      r3_nxt  = step_r3;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CHUNKS-1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r <= val_nxt;
    r3_r  <= r3_nxt;
    par_r <= par_nxt;
  end

  // mod 6 from mod 3 and parity: add 3 when the two parities disagree
  assign status.done = busy_r && (cnt_r == CNT_W'(CHUNKS-1));
  assign status.rem  = {1'b0, step_r3} + (((step_r3[0] ^ par_r) != 1'b0) ? 3'd3 : 3'd0);

endmodule

@@ hw/rtl/rendezvous_hash_select_core.sv @@
// Rendezvous proxy selector. Name bytes stream in on in_tdata, one per item,
// with in_tlast on the final byte; each is folded into a 64-bit djb2 hash
// (h*33 + byte). The final byte starts scoring: for every proxy the shared
// fold unit extends the name hash over the four ASCII digits of the proxy
// port and a remainder unit then reduces it mod 6 sixteen bits at a time;
// the result goes to the output register once that register is free.
// in_tready is low while scoring. The highest weight wins, the lowest index
// on ties, and the hash then restarts at 5381 for the next name.
module rendezvous_hash_select_core
  import rhs_pkg::*;
#(
  parameter int NUM_PROXIES = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] name_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] proxy_index, [16:3] proxy_port,
                                  // [19:17] winning_weight, [23:20] zero
);

  state_t state_r, state_nxt;

  logic [HASH_W-1:0]   hash_r, hash_nxt;
  logic [HASH_W-1:0]   work_r, work_nxt;
  logic [1:0]          digit_r, digit_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    best_i_r, best_i_nxt;
  logic [WEIGHT_W-1:0] best_w_r, best_w_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;

  logic [HASH_W-1:0]   fold_h, fold_out;
  logic [7:0]          fold_b;
  logic                mod_start;
  mod_status_t         mod_st;
  logic                in_acc, out_free, last_proxy;
  logic [PORT_W-1:0]   win_port;

  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign last_proxy = (idx_r == IDX_W'(NUM_PROXIES-1));
  assign win_port   = BASE_PORT + {{(PORT_W-IDX_W){1'b0}}, best_i_r};

  // shared fold operands: name byte while idle, port digits while scoring
  assign fold_h = (state_r == ST_IDLE) ? hash_r : work_r;
  assign fold_b = (state_r == ST_IDLE) ? in_tdata : PORT_ASCII[idx_r][digit_r];

  rhs_fold_unit u_fold (
    .hash_in  (fold_h),
    .byte_in  (fold_b),
    .hash_out (fold_out)
  );

  rhs_mod6_unit u_mod6 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .value  (fold_out),
    .status (mod_st)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (digit_r == 2'd3) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (mod_st.done) state_nxt = last_proxy ? ST_EMIT : ST_DIGIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_tready     = 1'b0;
    mod_start     = 1'b0;
    hash_nxt      = hash_r;
    work_nxt      = work_r;
    digit_nxt     = digit_r;
    idx_nxt       = idx_r;
    best_i_nxt    = best_i_r;
    best_w_nxt    = best_w_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          hash_nxt  = fold_out;
          work_nxt  = fold_out;
          digit_nxt = '0;
          idx_nxt   = '0;
        end
      end
      ST_DIGIT: begin
        work_nxt  = fold_out;
        digit_nxt = digit_r + 1'b1;
        if (digit_r == 2'd3) mod_start = 1'b1;
      end
      ST_MOD: begin
        if (mod_st.done) begin
          if (idx_r == '0 || mod_st.rem > best_w_r) begin
            best_w_nxt = mod_st.rem;
            best_i_nxt = idx_r;
          end
          if (!last_proxy) begin
            idx_nxt   = idx_r + 1'b1;
            work_nxt  = hash_r;
            digit_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, best_w_r, win_port, best_i_r};
          hash_nxt      = HASH_SEED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= HASH_SEED;
      out_valid_r <= 1'b0;
      digit_r     <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      digit_r     <= digit_nxt;
      idx_r       <= idx_nxt;
    end
    work_r     <= work_nxt;
    best_i_r   <= best_i_nxt;
    best_w_r   <= best_w_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ test/rendezvous_hash_select_core_tb.sv @@
module rendezvous_hash_select_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rhs_pkg::*;

  localparam int NPROX        = 6;
  localparam int NAME_ITEMS   = 1900;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [PORT_W-1:0]   port;
    logic [WEIGHT_W-1:0] wt;
  } pick_t;

  // one row per item; rep repeats a non-final byte, known rows carry a typed result
  typedef struct {
    logic [7:0] b;
    logic       last;
    int         rep;
    bit         known;
    pick_t      pick;
  } name_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  logic [HASH_W-1:0] name_hash;
  pick_t             pick_q[$];
  pick_t             pick_exp;
  logic              no_idle;
  int                errors;
  int                names_sent;
  int                bytes_sent;
  int                picks_seen;
  int                longest_name;

  // Single-byte names without wrap: after the three '9' digits the hash is
  // 3 mod 6 when the name hash is even and 0 when odd, so the last digit
  // alone decides: even -> port 9998, odd -> port 9995, both with weight 5.
  name_row_t dir_rows [14] = '{
    '{8'h01, 1'b1, 1,  1'b1, '{3'd5, 14'd9998, 3'd5}},
    '{8'h02, 1'b1, 1,  1'b1, '{3'd2, 14'd9995, 3'd5}},
    '{8'hFF, 1'b1, 1,  1'b1, '{3'd5, 14'd9998, 3'd5}},
    '{8'h00, 1'b1, 1,  1'b1, '{3'd2, 14'd9995, 3'd5}},
    '{8'h00, 1'b0, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'h80, 1'b0, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'h7F, 1'b1, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    // 11 bytes of 0xFF push the hash past 2^64
    '{8'hFF, 1'b0, 10, 1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'hFF, 1'b1, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'h55, 1'b0, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'hAA, 1'b1, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'h10, 1'b1, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'h11, 1'b1, 1,  1'b0, '{3'd0, 14'd0, 3'd0}},
    '{8'h12, 1'b1, 1,  1'b0, '{3'd0, 14'd0, 3'd0}}
  };

  rendezvous_hash_select_core #(
    .NUM_PROXIES(NPROX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // highest weight over all proxy ports, lowest index on ties
  function automatic pick_t score_name(logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] x;
    logic [HASH_W-1:0] w;
    int                port;
    pick_t             best;
    best = '0;
    for (int i = 0; i < NPROX; i++) begin
      port = int'(BASE_PORT) + i;
      x = h;
      for (int d = 1000; d >= 1; d /= 10)
        x = x * 64'd33 + 64'(48 + (port / d) % 10);
      w = x % 64'd6;
      if (i == 0 || w > HASH_W'(best.wt)) begin
        best.idx  = i[IDX_W-1:0];
        best.port = port[PORT_W-1:0];
        best.wt   = w[WEIGHT_W-1:0];
      end
    end
    return best;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, bit known, pick_t typed);
    if (!no_idle && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    name_hash = name_hash * 64'd33 + 64'(b);
    bytes_sent++;
    if (last) begin
      pick_q.push_back(known ? typed : score_name(name_hash));
      name_hash = HASH_SEED;
      names_sent++;
    end
  endtask

  task automatic note_mismatch(string what, pick_t want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: expected idx %0d port %0d weight %0d, got idx %0d port %0d weight %0d pad %h",
               $realtime, what, want.idx, want.port, want.wt,
               out_tdata[2:0], out_tdata[16:3], out_tdata[19:17], out_tdata[23:20]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      picks_seen++;
      if (pick_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0);
      end else begin
        pick_exp = pick_q.pop_front();
        if (out_tdata[2:0] != pick_exp.idx || out_tdata[16:3] != pick_exp.port ||
            out_tdata[19:17] != pick_exp.wt || out_tdata[23:20] != 4'd0)
          note_mismatch("selection mismatch", pick_exp);
      end
    end
  end

  // receiver: random stalls, one long hold-off so the core backs up
  initial begin
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!held && picks_seen >= 30) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int rand_items;
    int len;
    errors       = 0;
    names_sent   = 0;
    bytes_sent   = 0;
    picks_seen   = 0;
    longest_name = 0;
    rand_items   = 0;
    name_hash    = HASH_SEED;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tlast  <= 1'b0;
    no_idle   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      for (int k = 0; k < dir_rows[r].rep; k++)
        send_byte(dir_rows[r].b, dir_rows[r].last, dir_rows[r].known, dir_rows[r].pick);

    // mostly short names, some long enough to wrap the hash several times
    while (rand_items < NAME_ITEMS) begin
      no_idle <= (rand_items >= 700 && rand_items < 1100);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      if (len > longest_name)
        longest_name = len;
      for (int k = 0; k < len; k++)
        send_byte(8'($urandom_range(0, 255)), k == len - 1, 1'b0, '0);
      rand_items += len;
    end
    in_tvalid <= 1'b0;
    no_idle   <= 1'b0;

    while (pick_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pick_q.size() != 0)
      errors++;

    $display("covered %0d names in %0d bytes, longest random name %0d bytes",
             names_sent, bytes_sent, longest_name);
    $display("%0d proxy selections compared, %0d mismatches", picks_seen, errors);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
